[rtl/core/ttps_pkg.sv]
// shared types and constants for the transposition table probe/store block
// no dependencies
`default_nettype none

package ttps_pkg;

    localparam int INDEX_BITS = 10;
    localparam int SLOT_COUNT = 1 << INDEX_BITS;
    localparam int KEY_BITS   = 64;
    localparam int SCORE_BITS = 16;
    localparam int MOVE_BITS  = 16;
    localparam int DEPTH_BITS = 8;
    localparam int THR_BITS   = 15;

    typedef enum logic [1:0] {
        OP_PROBE = 2'd0,
        OP_STORE = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE  = 2'd0,
        KIND_EXACT = 2'd1,
        KIND_UPPER = 2'd2,
        KIND_LOWER = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic [SCORE_BITS-1:0] score;
        logic [MOVE_BITS-1:0]  move;
        logic [DEPTH_BITS-1:0] depth;
        logic [1:0]            kind;
    } slot_t;

    typedef struct packed {
        logic accept;
        logic sweep;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic sweep_last;
    } sts_t;

endpackage

`default_nettype wire

[rtl/core/ttps_dpath.sv]
// datapath: slot memory, sweep counter, probe evaluation and result register
// depends on ttps_pkg
`default_nettype none

module ttps_dpath (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire ttps_pkg::cmd_t                  cmd,
    output ttps_pkg::sts_t                       sts,
    input  wire logic [1:0]                      s_operation,
    input  wire logic [ttps_pkg::KEY_BITS-1:0]   s_position_key,
    input  wire logic signed [ttps_pkg::SCORE_BITS-1:0] s_new_score,
    input  wire logic [ttps_pkg::MOVE_BITS-1:0]  s_new_move,
    input  wire logic [ttps_pkg::DEPTH_BITS-1:0] s_search_depth,
    input  wire logic [1:0]                      s_bound_kind,
    input  wire logic signed [ttps_pkg::SCORE_BITS-1:0] s_window_low,
    input  wire logic signed [ttps_pkg::SCORE_BITS-1:0] s_window_high,
    input  wire logic [ttps_pkg::DEPTH_BITS-1:0] s_distance_from_root,
    input  wire logic [ttps_pkg::THR_BITS-1:0]   mate_threshold,
    output logic                                 m_cutoff_hit,
    output logic [ttps_pkg::MOVE_BITS-1:0]       m_found_move,
    output logic signed [ttps_pkg::SCORE_BITS-1:0] m_found_score
);
    import ttps_pkg::*;

    slot_t mem [SLOT_COUNT];

    logic [INDEX_BITS-1:0] sweep_cnt_reg;
    logic [INDEX_BITS-1:0] sweep_cnt_next;
    slot_t                 rd_reg;

    logic [1:0]            op_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [DEPTH_BITS-1:0] depth_reg;
    logic signed [SCORE_BITS-1:0] alpha_reg;
    logic signed [SCORE_BITS-1:0] beta_reg;
    logic [DEPTH_BITS-1:0] ply_reg;

    logic                  hit_reg;
    logic [MOVE_BITS-1:0]  move_reg;
    logic signed [SCORE_BITS-1:0] score_reg;

    logic                  mem_we;
    logic [INDEX_BITS-1:0] mem_waddr;
    slot_t                 mem_wdata;
    logic [INDEX_BITS-1:0] s_index;

    logic                  hit_next;
    logic [MOVE_BITS-1:0]  move_next;
    logic signed [SCORE_BITS-1:0] score_next;
    logic                  key_match;
    logic                  bound_ok;
    logic signed [SCORE_BITS:0] s_wide;
    logic signed [SCORE_BITS:0] thr_wide;
    logic signed [SCORE_BITS:0] adj_wide;

    assign s_index = s_position_key[INDEX_BITS-1:0];

    // write port: sweep writes empty slots, a store writes the new entry
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = sweep_cnt_reg;
        mem_wdata = '0;
        if (cmd.sweep) begin
            mem_we = 1'b1;
        end else if (cmd.accept && (s_operation == OP_STORE)) begin
            mem_we          = 1'b1;
            mem_waddr       = s_index;
            mem_wdata.valid = 1'b1;
            mem_wdata.key   = s_position_key;
            mem_wdata.score = s_new_score;
            mem_wdata.move  = s_new_move;
            mem_wdata.depth = s_search_depth;
            mem_wdata.kind  = s_bound_kind;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.accept) begin
            rd_reg <= mem[s_index];
        end
    end

    assign sweep_cnt_next = cmd.sweep ? sweep_cnt_reg + 1'b1 : sweep_cnt_reg;
    assign sts.sweep_last = &sweep_cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sweep_cnt_reg <= '0;
        end else begin
            sweep_cnt_reg <= sweep_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg    <= s_operation;
            key_reg   <= s_position_key;
            depth_reg <= s_search_depth;
            alpha_reg <= s_window_low;
            beta_reg  <= s_window_high;
            ply_reg   <= s_distance_from_root;
        end
    end

    // probe evaluation on the registered slot
    always_comb begin
        s_wide    = {rd_reg.score[SCORE_BITS-1], rd_reg.score};
        thr_wide  = $signed({2'b00, mate_threshold});
        key_match = rd_reg.valid && (rd_reg.key == key_reg) && (depth_reg <= rd_reg.depth);
        unique case (kind_t'(rd_reg.kind))
            KIND_EXACT: bound_ok = 1'b1;
            KIND_UPPER: bound_ok = ($signed(rd_reg.score) <= alpha_reg);
            KIND_LOWER: bound_ok = ($signed(rd_reg.score) >= beta_reg);
            default:    bound_ok = 1'b0;
        endcase
        if (s_wide > thr_wide) begin
            adj_wide = s_wide - $signed({1'b0, ply_reg});
        end else if (s_wide < -thr_wide) begin
            adj_wide = s_wide + $signed({1'b0, ply_reg});
        end else begin
            adj_wide = s_wide;
        end
        hit_next   = (op_reg == OP_PROBE) && key_match && bound_ok;
        move_next  = hit_next ? rd_reg.move : '0;
        score_next = hit_next ? adj_wide[SCORE_BITS-1:0] : '0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            hit_reg   <= hit_next;
            move_reg  <= move_next;
            score_reg <= score_next;
        end
    end

    assign m_cutoff_hit  = hit_reg;
    assign m_found_move  = move_reg;
    assign m_found_score = score_reg;

endmodule

`default_nettype wire

[rtl/core/ttps_ctrl.sv]
// controller: sequencer for sweeps, request intake and result hand-off
// depends on ttps_pkg
`default_nettype none

module ttps_ctrl (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [1:0]     s_operation,
    output logic                m_valid,
    input  wire logic           m_ready,
    output ttps_pkg::cmd_t      cmd,
    input  wire ttps_pkg::sts_t sts
);
    import ttps_pkg::*;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_INIT: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = (s_operation == OP_CLEAR) ? ST_CLEAR : ST_RESULT;
                end
            end
            ST_CLEAR: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next = ST_RESULT;
                end
            end
            ST_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_INIT;
        endcase
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    assign m_valid = m_valid_reg;

    a_clear_sweeps: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_operation == OP_CLEAR)) |=> (state_reg == ST_CLEAR))
        else $error("clear request did not start a sweep");

    a_req_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_operation != OP_CLEAR)) |=> (state_reg == ST_RESULT))
        else $error("request did not move to result hand-off");

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten before it was taken");

    a_sweep_no_write: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.sweep |-> !cmd.accept)
        else $error("request taken during a sweep");

endmodule

`default_nettype wire

[rtl/core/transposition_table_probe_store_top.sv]
// top level of the transposition table probe/store block: apb register, controller, datapath
// depends on ttps_pkg, ttps_ctrl, ttps_dpath
// a result passes the slot read register, then the result register
// a clear first sweeps all slots; a new request waits until the last result is loaded
// reset: synchronous active-low; a sweep empties all 1024 slots, s_ready low meanwhile
// mate_threshold resets to 31000; apb writes are taken at any time
`default_nettype none

module transposition_table_probe_store_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_operation,
    input  wire logic [63:0] s_position_key,
    input  wire logic signed [15:0] s_new_score,
    input  wire logic [15:0] s_new_move,
    input  wire logic [7:0]  s_search_depth,
    input  wire logic [1:0]  s_bound_kind,
    input  wire logic signed [15:0] s_window_low,
    input  wire logic signed [15:0] s_window_high,
    input  wire logic [7:0]  s_distance_from_root,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_cutoff_hit,
    output logic [15:0]      m_found_move,
    output logic signed [15:0] m_found_score,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [1:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import ttps_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // mate threshold register, the only register (byte address 0; paddr is not decoded)
    logic [THR_BITS-1:0] thr_reg;
    logic [THR_BITS-1:0] thr_next;
    logic                reg_wr;

    assign pready = 1'b1;
    assign reg_wr = psel && penable && pwrite;
    assign thr_next = reg_wr ? pwdata[THR_BITS-1:0] : thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg <= THR_BITS'(31000);
        end else begin
            thr_reg <= thr_next;
        end
    end

    // paddr carries only the byte offset within the single word
    assign prdata = (paddr[1:0] == 2'b00) ? {{(32 - THR_BITS){1'b0}}, thr_reg}
                                          : {{(32 - THR_BITS){1'b0}}, thr_reg};

    // sequencer: sweeps, request intake, result hand-off
    ttps_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .cmd         (cmd),
        .sts         (sts)
    );

    // slot memory and probe evaluation
    ttps_dpath u_dpath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .sts                  (sts),
        .s_operation          (s_operation),
        .s_position_key       (s_position_key),
        .s_new_score          (s_new_score),
        .s_new_move           (s_new_move),
        .s_search_depth       (s_search_depth),
        .s_bound_kind         (s_bound_kind),
        .s_window_low         (s_window_low),
        .s_window_high        (s_window_high),
        .s_distance_from_root (s_distance_from_root),
        .mate_threshold       (thr_reg),
        .m_cutoff_hit         (m_cutoff_hit),
        .m_found_move         (m_found_move),
        .m_found_score        (m_found_score)
    );

endmodule

`default_nettype wire

[tb/transposition_table_probe_store_top_tb.sv]
// self-checking testbench for transposition_table_probe_store_top: probe, store and clear beats
// checked against an in-bench table predictor; needs ttps_pkg and the block's rtl only
`timescale 1ns / 100ps

module transposition_table_probe_store_top_tb;
    import ttps_pkg::*;

    localparam logic [1:0] OP_UNUSED          = 2'd3;   // code with no meaning, must be ignored
    localparam logic [1:0] REG_MATE_THRESHOLD = 2'd0;
    localparam int         STALL_LIMIT        = 6000;   // far above the clear sweep of the whole table
    localparam int         POOL_SIZE          = 16;
    localparam int         CHUNK_ITEMS        = 95;
    localparam int         CHUNKS_PER_PHASE   = 4;
    localparam int         PHASES             = 5;

    typedef struct {
        logic [1:0]            op;
        logic [KEY_BITS-1:0]   key;
        logic signed [15:0]    score;
        logic [MOVE_BITS-1:0]  move;
        logic [DEPTH_BITS-1:0] depth;
        logic [1:0]            bound;
        logic signed [15:0]    alpha;
        logic signed [15:0]    beta;
        logic [7:0]            ply;
    } request_t;

    typedef struct packed {
        logic                 hit;
        logic [MOVE_BITS-1:0] move;
        logic signed [15:0]   score;
    } lookup_t;

    // clock, reset and bus signals, all known from time zero
    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        m_ready = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [1:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    request_t    drv_req = '{default: '0};

    wire         s_ready;
    wire         m_valid;
    wire         m_cutoff_hit;
    wire [15:0]  m_found_move;
    wire [15:0]  m_found_score;
    wire [31:0]  prdata;
    wire         pready;

    // request backlog and expected lookups, in beat order
    request_t request_backlog[$];
    lookup_t  expected_lookups[$];

    // predictor copy of the table and of the register
    bit                    slot_live  [SLOT_COUNT];
    logic [KEY_BITS-1:0]   slot_key_m [SLOT_COUNT];
    logic signed [15:0]    slot_score_m [SLOT_COUNT];
    logic [MOVE_BITS-1:0]  slot_move_m  [SLOT_COUNT];
    logic [DEPTH_BITS-1:0] slot_depth_m [SLOT_COUNT];
    logic [1:0]            slot_bound_m [SLOT_COUNT];
    logic [THR_BITS-1:0]   mate_limit = 15'd31000;

    // stimulus side bookkeeping: slots ever stored, key pool for repeated hits
    bit                  slot_seen [SLOT_COUNT];
    int                  written_slots[$];
    logic [KEY_BITS-1:0] key_pool [POOL_SIZE];
    int                  pool_score [POOL_SIZE];

    bit idle_on  = 1'b1;
    int src_idle = 0;
    int sink_idle = 0;
    int stall_cycles = 0;
    int mismatch_count = 0;
    int n_probe = 0, n_hit = 0, n_store = 0, n_clear = 0, n_unused = 0;
    int rand_thr;

    transposition_table_probe_store_top dut (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_operation          (drv_req.op),
        .s_position_key       (drv_req.key),
        .s_new_score          (drv_req.score),
        .s_new_move           (drv_req.move),
        .s_search_depth       (drv_req.depth),
        .s_bound_kind         (drv_req.bound),
        .s_window_low         (drv_req.alpha),
        .s_window_high        (drv_req.beta),
        .s_distance_from_root (drv_req.ply),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_cutoff_hit         (m_cutoff_hit),
        .m_found_move         (m_found_move),
        .m_found_score        (m_found_score),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready)
    );

    // 12 ns clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // saturate to the 16-bit score range
    function automatic logic signed [15:0] sat16(input int v);
        if (v > 32767)
            return 16'sh7fff;
        if (v < -32768)
            return 16'sh8000;
        return v[15:0];
    endfunction

    function automatic request_t make_request(
        input logic [1:0] op, input logic [63:0] key, input logic signed [15:0] score,
        input logic [15:0] move, input logic [7:0] depth, input logic [1:0] bound,
        input logic signed [15:0] alpha, input logic signed [15:0] beta, input logic [7:0] ply
    );
        request_t r;
        r.op    = op;
        r.key   = key;
        r.score = score;
        r.move  = move;
        r.depth = depth;
        r.bound = bound;
        r.alpha = alpha;
        r.beta  = beta;
        r.ply   = ply;
        return r;
    endfunction

    // fully random request with the given code
    function automatic request_t random_request(input logic [1:0] op);
        return make_request(op, {$urandom, $urandom}, 16'($urandom), 16'($urandom),
                            8'($urandom), 2'($urandom), 16'($urandom), 16'($urandom),
                            8'($urandom));
    endfunction

    // predictor: applies one accepted request beat to the table copy and
    // queues the lookup result it must produce
    task automatic apply_to_table(input request_t r);
        lookup_t               res;
        logic [INDEX_BITS-1:0] idx;
        int                    s;
        int                    thr;
        int                    sc;
        res = '0;
        idx = r.key[INDEX_BITS-1:0];
        thr = int'(mate_limit);
        case (r.op)
            OP_STORE: begin
                n_store++;
                slot_live[idx]    = 1'b1;
                slot_key_m[idx]   = r.key;
                slot_score_m[idx] = r.score;
                slot_move_m[idx]  = r.move;
                slot_depth_m[idx] = r.depth;
                slot_bound_m[idx] = r.bound;
            end
            OP_CLEAR: begin
                n_clear++;
                slot_live = '{default: 1'b0};
            end
            OP_PROBE: begin
                n_probe++;
                if (slot_live[idx] && slot_key_m[idx] == r.key && r.depth <= slot_depth_m[idx]) begin
                    // cutoff test on the stored score, before any ply adjustment
                    s = int'(slot_score_m[idx]);
                    if (slot_bound_m[idx] == KIND_EXACT ||
                        (slot_bound_m[idx] == KIND_UPPER && s <= r.alpha) ||
                        (slot_bound_m[idx] == KIND_LOWER && s >= r.beta)) begin
                        if (s > thr)
                            sc = s - int'(r.ply);
                        else if (s < -thr)
                            sc = s + int'(r.ply);
                        else
                            sc = s;
                        res.hit   = 1'b1;
                        res.move  = slot_move_m[idx];
                        res.score = sc[15:0];
                    end
                end
            end
            default: n_unused++;
        endcase
        expected_lookups.push_back(res);
    endtask

    function automatic void flag(input string what, input longint want, input longint got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    // stimulus side: note stored slots so that no never-written slot is probed
    function automatic void queue_request(input request_t r);
        int idx;
        idx = int'(r.key[INDEX_BITS-1:0]);
        if (r.op == OP_STORE && !slot_seen[idx]) begin
            slot_seen[idx] = 1'b1;
            written_slots.push_back(idx);
        end
        request_backlog.push_back(r);
    endfunction

    // fresh key pool; the top four share a slot with the first four to force replacements
    function automatic void refresh_pool();
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i]   = {$urandom, $urandom};
            pool_score[i] = 0;
        end
        for (int i = POOL_SIZE - 4; i < POOL_SIZE; i++)
            key_pool[i][INDEX_BITS-1:0] = key_pool[i - (POOL_SIZE - 4)][INDEX_BITS-1:0];
    endfunction

    // mostly stores and probes on pooled keys with scores near the window and
    // the mate threshold; a few clears, unused codes and stray keys
    task automatic queue_random_request();
        request_t r;
        int       pick;
        int       k;
        int       d;
        int       v;
        int       thr;
        bit       pooled;
        r    = random_request(OP_PROBE);
        k    = $urandom_range(0, POOL_SIZE - 1);
        thr  = int'(mate_limit);
        pick = $urandom_range(0, 999);
        if (pick < 8) begin
            r.op = OP_CLEAR;
        end else if (pick < 16) begin
            r.op = OP_UNUSED;
        end else if (pick < 440) begin
            r.op   = OP_STORE;
            pooled = ($urandom_range(0, 99) < 85);
            if (pooled)
                r.key = key_pool[k];
            if ($urandom_range(0, 3) == 0) begin
                d = $urandom_range(0, 300);
                v = thr + d - 4;
                if ($urandom_range(0, 1))
                    v = -v;
                r.score = sat16(v);
            end
            if ($urandom_range(0, 9) < 7)
                r.depth = 8'($urandom_range(0, 30));
            if (pooled)
                pool_score[k] = int'(r.score);
        end else begin
            if ($urandom_range(0, 9) != 0)
                r.key = key_pool[k];
            else if (written_slots.size() != 0)
                r.key[INDEX_BITS-1:0] =
                    INDEX_BITS'(written_slots[$urandom_range(0, written_slots.size() - 1)]);
            if ($urandom_range(0, 9) < 7)
                r.depth = 8'($urandom_range(0, 30));
            if ($urandom_range(0, 9) < 6) begin
                d = $urandom_range(0, 6);
                r.alpha = sat16(pool_score[k] + d - 3);
                d = $urandom_range(0, 6);
                r.beta = sat16(pool_score[k] + d - 3);
            end
            // a slot never stored since reset is not probed: store to it instead
            if (!slot_seen[r.key[INDEX_BITS-1:0]])
                r.op = OP_STORE;
        end
        queue_request(r);
    endtask

    // register write in setup and access cycles, then read back; only called
    // with the block idle
    task automatic write_threshold(input logic [THR_BITS-1:0] value);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= REG_MATE_THRESHOLD;
        pwdata  <= {17'd0, value};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        // register takes the value at this edge
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        mate_limit = value;
        @(negedge aclk);
        if (prdata !== {17'd0, value})
            flag("mate_threshold readback", longint'(value), longint'(prdata));
        if (pready !== 1'b1)
            flag("pready", 1, longint'(pready));
    endtask

    // waits at the falling edge until every beat is sent and answered
    task automatic wait_drained();
        do
            @(negedge aclk);
        while (request_backlog.size() != 0 || s_valid || expected_lookups.size() != 0);
    endtask

    // request driver: predicts each accepted beat, then loads the next one
    // from the backlog unless a random idle burst is running
    always @(posedge aclk) begin
        request_t next_req;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                apply_to_table(drv_req);
            if (!s_valid || s_ready) begin
                if (src_idle > 0) begin
                    src_idle--;
                    s_valid <= 1'b0;
                end else if (request_backlog.size() != 0) begin
                    next_req = request_backlog.pop_front();
                    drv_req  <= next_req;
                    s_valid  <= 1'b1;
                    // gap after this beat
                    if (idle_on && $urandom_range(0, 5) == 0)
                        src_idle = $urandom_range(1, 10);
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor: each result beat against the oldest expected lookup,
    // plus random back-pressure bursts on m_ready
    always @(posedge aclk) begin
        lookup_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_lookups.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: result beat with nothing expected", $time);
                end else begin
                    want = expected_lookups.pop_front();
                    if (m_cutoff_hit === 1'b1)
                        n_hit++;
                    if (m_cutoff_hit !== want.hit)
                        flag("cutoff_hit", want.hit, m_cutoff_hit);
                    if (m_found_move !== want.move)
                        flag("found_move", want.move, m_found_move);
                    if (m_found_score !== want.score)
                        flag("found_score", want.score, $signed(m_found_score));
                end
            end
            if (sink_idle > 0) begin
                sink_idle--;
                m_ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                sink_idle = $urandom_range(0, 9);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles with no beat on either channel
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
            $display("transposition_table_probe_store_top_tb: done, errors");
            $finish;
        end
    end

    // stimulus: reset, directed beats at the reset threshold, then random
    // phases each under its own mate threshold setting
    initial begin
        logic [63:0]   key_a;
        logic [63:0]   key_b;
        logic [63:0]   key_c;
        logic [63:0]   key_d;
        logic [63:0]   key_e;
        logic [14:0]   thr_value;
        key_a = '1;
        key_b = 64'h0;
        key_c = 64'h8000_0000_0000_0000;   // same slot as key_b
        key_d = 64'h1;
        key_e = 64'h2;
        rand_thr = $urandom_range(1, 32766);

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // extremes: full score, full ply, full depth
        queue_request(make_request(OP_STORE, key_a, 16'sh7fff, 16'hffff, 8'd255, KIND_EXACT,
                                   0, 0, 0));
        queue_request(make_request(OP_PROBE, key_a, 0, 0, 8'd255, 0, 0, 0, 8'd255));
        queue_request(make_request(OP_PROBE, key_a, 0, 0, 8'd0, 0, 16'sh7fff, 16'sh8000, 8'd0));
        // upper bound at the most negative score, mate adjusted upwards
        queue_request(make_request(OP_STORE, key_b, 16'sh8000, 16'h0000, 8'd0, KIND_UPPER,
                                   0, 0, 0));
        queue_request(make_request(OP_PROBE, key_b, 0, 0, 8'd0, 0, 16'sh8000, 0, 8'd255));
        // depth too shallow, then same slot with a different key
        queue_request(make_request(OP_PROBE, key_b, 0, 0, 8'd1, 0, 16'sh8000, 0, 8'd3));
        queue_request(make_request(OP_PROBE, key_c, 0, 0, 8'd0, 0, 16'sh7fff, 16'sh8000, 8'd3));
        // replacement; score equal to the threshold is not adjusted
        queue_request(make_request(OP_STORE, key_c, 16'sd31000, 16'h1234, 8'd10, KIND_LOWER,
                                   0, 0, 0));
        queue_request(make_request(OP_PROBE, key_c, 0, 0, 8'd10, 0, 0, 16'sd31000, 8'd7));
        // key matches but no cutoff: nothing returned
        queue_request(make_request(OP_PROBE, key_c, 0, 0, 8'd10, 0, 0, 16'sd31001, 8'd7));
        queue_request(make_request(OP_PROBE, key_b, 0, 0, 8'd0, 0, 16'sh7fff, 0, 8'd7));
        // cutoff decided on the unadjusted score
        queue_request(make_request(OP_STORE, key_d, -16'sd31005, 16'h00ff, 8'd5, KIND_UPPER,
                                   0, 0, 0));
        queue_request(make_request(OP_PROBE, key_d, 0, 0, 8'd5, 0, -16'sd31003, 0, 8'd5));
        queue_request(make_request(OP_PROBE, key_d, 0, 0, 8'd5, 0, -16'sd31006, 0, 8'd5));
        // bound kind none never gives a hit
        queue_request(make_request(OP_STORE, key_e, 16'sd100, 16'haaaa, 8'd200, KIND_NONE,
                                   0, 0, 0));
        queue_request(make_request(OP_PROBE, key_e, 0, 0, 8'd0, 0, 16'sh7fff, 16'sh8000, 8'd1));
        // unused code must leave the table alone
        queue_request(random_request(OP_UNUSED));
        queue_request(make_request(OP_PROBE, key_a, 0, 0, 8'd0, 0, 0, 0, 8'd1));
        // whole-table clear, then refill one slot
        queue_request(random_request(OP_CLEAR));
        queue_request(make_request(OP_PROBE, key_a, 0, 0, 8'd0, 0, 0, 0, 8'd1));
        queue_request(make_request(OP_STORE, key_a, 16'sd0, 16'h8000, 8'd0, KIND_EXACT, 0, 0, 0));
        queue_request(make_request(OP_PROBE, key_a, 0, 0, 8'd0, 0, 0, 0, 8'd9));
        wait_drained();

        // random phases: threshold extremes, a low value, a random one, back to reset value
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0:       thr_value = 15'd0;
                1:       thr_value = 15'd32767;
                2:       thr_value = 15'd250;
                3:       thr_value = rand_thr[14:0];
                default: thr_value = 15'd31000;
            endcase
            write_threshold(thr_value);
            for (int c = 0; c < CHUNKS_PER_PHASE; c++) begin
                // keep the backlog topped up so chunks run back to back
                while (request_backlog.size() > 4)
                    @(negedge aclk);
                idle_on = (p == PHASES - 1 && c == CHUNKS_PER_PHASE - 1) ? 1'b0
                          : ($urandom_range(0, 3) != 0);
                refresh_pool();
                repeat (CHUNK_ITEMS) queue_random_request();
            end
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        $display("covered %0d probes (%0d cutoff hits), %0d stores, %0d clears, %0d unused codes",
                 n_probe, n_hit, n_store, n_clear, n_unused);
        $display("mate threshold settings 31000, 0, 32767, 250, %0d; %0d mismatches",
                 rand_thr[14:0], mismatch_count);
        if (mismatch_count == 0 && expected_lookups.size() == 0) begin
            $display("transposition_table_probe_store_top_tb: done, clean");
        end else begin
            $display("transposition_table_probe_store_top_tb: done, errors");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/ttps_pkg.sv
rtl/core/ttps_dpath.sv
rtl/core/ttps_ctrl.sv
rtl/core/transposition_table_probe_store_top.sv
tb/transposition_table_probe_store_top_tb.sv
